// ===== hdl/tte_pkg.sv =====
// ----------------------------------------------------------------------------
// tte_pkg: shared types and codes of the timeout table engine
// Item modes, result kinds and status codes, and the layout of a slot entry.
// ----------------------------------------------------------------------------
package tte_pkg;

  // Item modes
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_ACK       = 2'd0;
  localparam logic [1:0] KIND_EXPIRED   = 2'd1;
  localparam logic [1:0] KIND_IDLE_TICK = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_ZERO_DELAY  = 2'd1;
  localparam logic [1:0] STATUS_NOT_RUNNING = 2'd2;

  localparam logic [31:0] DELAY_FOREVER = 32'hFFFF_FFFF;

  // One slot as stored in the slot memory
  typedef struct packed {
    logic [31:0] wakeup;
    logic [31:0] period;
    logic        periodic;
    logic        for_task;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Outcome of the expiry check for one slot
  typedef struct packed {
    logic due;
    logic rearm;
    logic task_wake;
  } verdict_t;

endpackage

// ===== hdl/timeout_table_engine.sv =====
// ----------------------------------------------------------------------------
// timeout_table_engine: tick counter and timeout slot table
// Arms, frees and expires timeout slots against a 32-bit tick counter.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Add, remove and
// refused ticks (core_running low) give a single result on done in the next
// cycle and busy never rises, so one such transaction can follow another
// every cycle. A tick keeps busy high while it scans: the slot memory has one
// read port and the engine reads one slot per cycle, then checks the last
// slot read and closes the scan. Expired slots come out in ascending order,
// one per done strobe, the last one marked by last; a tick with nothing due
// gives one result of kind 2. The receiver cannot stall: every result is on
// the ports for exactly one cycle. The user must write core_running through
// cfg_we / cfg_wdata while the engine is idle; the engine does not enforce it.
// Slot contents are undefined after reset; the armed bits gate them.
// ----------------------------------------------------------------------------
module timeout_table_engine #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  // command
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [3:0]  slot,
  input  logic [31:0] delay,
  input  logic        periodic,
  input  logic [31:0] period,
  input  logic        for_task,
  input  logic [7:0]  tick_step,
  // result
  output logic        done,
  output logic [1:0]  kind,
  output logic [1:0]  status,
  output logic [3:0]  expired_slot,
  output logic        task_wake,
  output logic        rearmed,
  output logic [31:0] tick_now,
  output logic        last
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t state;

  logic              core_running;
  logic [31:0]       tick_count;
  logic [31:0]       old_count;
  logic [7:0]        step_r;
  logic [SLOTS-1:0]  armed;

  // scan pipeline: cnt issues reads, chk_* is the slot whose data is back
  logic [CW-1:0]     cnt;
  logic              chk_vld;
  logic [AW-1:0]     chk_idx;

  // held expiry, emitted once the next one (or the end of scan) is known
  logic              pend_vld;
  logic [3:0]        pend_slot;
  logic              pend_task;
  logic              pend_rearm;

  logic              accept;
  logic              issuing;
  logic              chk_hit;
  logic              slot_in_range;
  logic              add_ok;
  logic [6:0]        slot_ext;
  logic [AW-1:0]     slot_idx;

  tte_pkg::entry_t   add_entry;
  tte_pkg::entry_t   rd_entry;
  tte_pkg::entry_t   rearm_entry;
  tte_pkg::verdict_t verdict;
  logic [31:0]       wakeup_next;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [tte_pkg::ENTRY_W-1:0] ram_wdata;
  logic [tte_pkg::ENTRY_W-1:0] ram_rdata;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign issuing = (cnt < CW'(SLOTS));

  assign slot_ext      = {3'd0, slot};
  assign slot_in_range = (slot_ext < 7'(SLOTS));
  assign slot_idx      = slot_ext[AW-1:0];

  // arm only on a real delay to an existing slot; zero and forever arm nothing
  assign add_ok = accept && (mode == tte_pkg::MODE_ADD) && (delay != 32'd0) &&
                  (delay != tte_pkg::DELAY_FOREVER) && slot_in_range;

  assign add_entry.wakeup   = tick_count + delay;
  assign add_entry.period   = period;
  assign add_entry.periodic = periodic;
  assign add_entry.for_task = for_task;

  assign rd_entry = tte_pkg::entry_t'(ram_rdata);

  tte_due u_due (
    .entry       (rd_entry),
    .old_count   (old_count),
    .new_count   (tick_count),
    .step        (step_r),
    .verdict     (verdict),
    .wakeup_next (wakeup_next)
  );

  assign chk_hit = chk_vld && armed[chk_idx] && verdict.due;

  always_comb begin
    rearm_entry        = rd_entry;
    rearm_entry.wakeup = wakeup_next;
  end

  // Share the write port: adds while idle, periodic re-arms during a scan.
  // A re-arm writes the checked slot while the next slot is read, so the
  // two never collide.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_idx;
    ram_wdata = add_entry;
    case (state)
      ST_IDLE: begin
        ram_we = add_ok;
      end
      ST_SCAN: begin
        ram_we    = chk_hit && verdict.rearm;
        ram_waddr = chk_idx;
        ram_wdata = rearm_entry;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tte_ram #(
    .WIDTH (tte_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      core_running <= 1'b0;
      tick_count   <= 32'd0;
      armed        <= '0;
      cnt          <= '0;
      chk_vld      <= 1'b0;
      pend_vld     <= 1'b0;
      done         <= 1'b0;
      last         <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_we) begin
        core_running <= cfg_wdata;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            // default: one acknowledge with the unchanged counter
            done         <= 1'b1;
            last         <= 1'b1;
            kind         <= tte_pkg::KIND_ACK;
            status       <= tte_pkg::STATUS_OK;
            expired_slot <= 4'd0;
            task_wake    <= 1'b0;
            rearmed      <= 1'b0;
            tick_now     <= tick_count;
            case (mode)
              tte_pkg::MODE_TICK: begin
                if (core_running) begin
                  // advance now, report after the scan
                  done       <= 1'b0;
                  old_count  <= tick_count;
                  tick_count <= tick_count + {24'd0, tick_step};
                  step_r     <= tick_step;
                  cnt        <= '0;
                  chk_vld    <= 1'b0;
                  pend_vld   <= 1'b0;
                  state      <= ST_SCAN;
                end else begin
                  status <= tte_pkg::STATUS_NOT_RUNNING;
                end
              end
              tte_pkg::MODE_ADD: begin
                if (delay == 32'd0) begin
                  status <= tte_pkg::STATUS_ZERO_DELAY;
                end else if (add_ok) begin
                  armed[slot_idx] <= 1'b1;
                end
              end
              tte_pkg::MODE_REMOVE: begin
                if (slot_in_range) begin
                  armed[slot_idx] <= 1'b0;
                end
              end
              default: begin
                status <= tte_pkg::STATUS_OK;
              end
            endcase
          end
        end

        ST_SCAN: begin
          chk_vld <= issuing;
          chk_idx <= cnt[AW-1:0];
          if (issuing) begin
            cnt <= cnt + CW'(1);
          end

          if (chk_hit) begin
            // free one-shots and task waits; periodic ones stay armed
            if (!verdict.rearm) begin
              armed[chk_idx] <= 1'b0;
            end
            // release the held expiry, not the last one
            if (pend_vld) begin
              done         <= 1'b1;
              last         <= 1'b0;
              kind         <= tte_pkg::KIND_EXPIRED;
              status       <= tte_pkg::STATUS_OK;
              expired_slot <= pend_slot;
              task_wake    <= pend_task;
              rearmed      <= pend_rearm;
              tick_now     <= tick_count;
            end
            pend_vld   <= 1'b1;
            pend_slot  <= 4'(chk_idx);
            pend_task  <= verdict.task_wake;
            pend_rearm <= verdict.rearm;
          end

          if (!issuing && !chk_vld) begin
            // close the scan: flush the held expiry, or report a quiet tick
            done         <= 1'b1;
            last         <= 1'b1;
            status       <= tte_pkg::STATUS_OK;
            tick_now     <= tick_count;
            if (pend_vld) begin
              kind         <= tte_pkg::KIND_EXPIRED;
              expired_slot <= pend_slot;
              task_wake    <= pend_task;
              rearmed      <= pend_rearm;
            end else begin
              kind         <= tte_pkg::KIND_IDLE_TICK;
              expired_slot <= 4'd0;
              task_wake    <= 1'b0;
              rearmed      <= 1'b0;
            end
            pend_vld <= 1'b0;
            state    <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // Add and remove transactions answer in the next cycle with a single result.
  assert property (@(posedge clk) disable iff (rst)
    accept && (mode != tte_pkg::MODE_TICK) |=> done && last && !busy)
    else $error("add/remove transaction did not complete in one cycle");

  // A tick while the kernel is stopped is refused at once.
  assert property (@(posedge clk) disable iff (rst)
    accept && (mode == tte_pkg::MODE_TICK) && !core_running
      |=> done && last && (status == tte_pkg::STATUS_NOT_RUNNING))
    else $error("tick while stopped was not refused");

  // The final result of a transaction leaves the engine idle.
  assert property (@(posedge clk) disable iff (rst)
    done && last |-> !busy)
    else $error("last result shown while still busy");

  // A re-arm writes back only a slot that is armed.
  assert property (@(posedge clk) disable iff (rst)
    ram_we && (state == ST_SCAN) |-> armed[chk_idx] && chk_vld)
    else $error("re-arm write to a slot that is not armed");

endmodule

// ===== hdl/tte_ram.sv =====
// ----------------------------------------------------------------------------
// tte_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tte_due.sv =====
// ----------------------------------------------------------------------------
// tte_due: expiry check for one slot
// Wrap-aware test that the wakeup falls in the span just passed, plus the
// re-arm wakeup of a periodic timer.
// ----------------------------------------------------------------------------
module tte_due (
  input  tte_pkg::entry_t   entry,
  input  logic [31:0]       old_count,
  input  logic [31:0]       new_count,
  input  logic [7:0]        step,
  output tte_pkg::verdict_t verdict,
  output logic [31:0]       wakeup_next
);

  logic [31:0] span;

  assign span = entry.wakeup - old_count;

  // due when 1 <= wakeup - old <= step, modulo 2^32
  assign verdict.due       = (span != 32'd0) && (span <= {24'd0, step});
  // task waits are never re-armed, even when marked periodic
  assign verdict.rearm     = !entry.for_task && entry.periodic;
  assign verdict.task_wake = entry.for_task;
  assign wakeup_next       = new_count + entry.period;

endmodule
